@@ rtl/core/ttc_pkg.sv @@
// Shared types, widths and helpers for the triangle tangent block.
// No dependencies; every module of the block imports this package.
package ttc_pkg;

  localparam int INDEX_BITS = 16;
  localparam int COORD_BITS = 16;

  // delta widths: raw difference, then scaled down for very wide coordinates
  localparam int RAW_DW    = COORD_BITS + 1;
  localparam int PRE_SHIFT = (COORD_BITS > 30) ? (COORD_BITS - 30) : 0;
  localparam int DW        = RAW_DW - PRE_SHIFT;
  localparam int CW        = 2 * DW + 1;          // cross terms and determinant
  localparam int NW        = (CW > 31) ? CW : 31; // magnitudes during normalize

  localparam int MUL_W  = 32;
  localparam int SQ_W   = 64;
  localparam int ROOT_W = 32;
  localparam int MAG_W  = 30;
  localparam int QW     = 17;
  localparam int FRAC   = 14;
  localparam int NUM_W  = MAG_W + FRAC + 2;

  localparam logic [15:0] ONE_Q14 = 16'd16384;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] position_x;
    logic signed [COORD_BITS-1:0] position_y;
    logic signed [COORD_BITS-1:0] position_z;
    logic signed [COORD_BITS-1:0] tex_u;
    logic signed [COORD_BITS-1:0] tex_v;
    logic        [INDEX_BITS-1:0] vertex_index;
  } vtx_in_t;

  typedef struct packed {
    logic signed [15:0]           tangent_x;
    logic signed [15:0]           tangent_y;
    logic signed [15:0]           tangent_z;
    logic        [INDEX_BITS-1:0] first_index;
    logic        [INDEX_BITS-1:0] second_index;
    logic        [INDEX_BITS-1:0] third_index;
    logic                         degenerate;
  } tan_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // difference scaled toward zero for wide coordinates
  function automatic logic signed [DW-1:0] shrink(input logic signed [RAW_DW-1:0] x);
    logic [RAW_DW-1:0] m;
    logic [RAW_DW-1:0] s;
    logic [RAW_DW-1:0] r;
    m = x[RAW_DW-1] ? (~x + 1'b1) : x;
    s = m >> PRE_SHIFT;
    r = x[RAW_DW-1] ? (~s + 1'b1) : s;
    return $signed(r[DW-1:0]);
  endfunction

endpackage

@@ rtl/core/ttc_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on ttc_pkg.
module ttc_mul (
  input  logic                              clk,
  input  logic signed [ttc_pkg::MUL_W-1:0]  a,
  input  logic signed [ttc_pkg::MUL_W-1:0]  b,
  output logic signed [2*ttc_pkg::MUL_W-1:0] p
);
  import ttc_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ rtl/core/ttc_root.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on ttc_pkg.
module ttc_root (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ttc_pkg::SQ_W-1:0]      radicand,
  output ttc_pkg::unit_stat_t           stat,
  output logic [ttc_pkg::ROOT_W-1:0]    root
);
  import ttc_pkg::*;

  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] acc;
  logic [SQ_W-1:0] bitv;
  logic [SQ_W-1:0] trial;

  assign trial = acc + bitv;
  assign root  = acc[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= !start && stat.busy && bitv[0];
      if (start) begin
        rem       <= radicand;
        acc       <= '0;
        bitv      <= SQ_W'(1) << (SQ_W - 2);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/ttc_div.sv @@
// Restoring divider: rounded (mag * 2^14) / len, one quotient bit per cycle.
// Depends on ttc_pkg.
module ttc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ttc_pkg::MAG_W-1:0]     mag,
  input  logic [ttc_pkg::ROOT_W-1:0]    den,
  output ttc_pkg::unit_stat_t           stat,
  output logic [ttc_pkg::QW-1:0]        quo
);
  import ttc_pkg::*;

  logic [NUM_W-1:0]  numer;
  logic [ROOT_W-1:0] rem;
  logic [QW-1:0]     low;
  logic [ROOT_W:0]   trial;
  logic [4:0]        cnt;

  assign numer = (NUM_W'(mag) << FRAC) + NUM_W'(den >> 1);
  assign trial = {rem, low[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= !start && stat.busy && (cnt == 5'(QW - 1));
      if (start) begin
        // quotient stays below 2^QW, so the top bits start below den
        rem       <= ROOT_W'(numer >> QW);
        low       <= numer[QW-1:0];
        quo       <= '0;
        cnt       <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= ROOT_W'(trial - {1'b0, den});
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= trial[ROOT_W-1:0];
          quo <= {quo[QW-2:0], 1'b0};
        end
        low <= low << 1;
        cnt <= cnt + 5'd1;
        if (cnt == 5'(QW - 1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/triangle_tangent_calc.sv @@
// Triangle tangent from UV: groups vertices by three, one unit tangent per triangle.
// Vertices one and two of a triangle are only held and give no result.
// The third vertex runs through the shared multiplier, root and divider to its
// result; a degenerate triangle skips normalize, root and divide and gives zero.
// One triangle at a time; a new result waits on a stalled one, stalling the input.
// Synchronous active-high reset clears the vertex count, sequencer and output valid.
module triangle_tangent_calc (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ttc_pkg::vtx_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ttc_pkg::tan_out_t out_data
);
  import ttc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_CHECK, S_NORM, S_SQ, S_ROOT, S_DIV, S_OUT
  } state_t;

  localparam logic [NW-1:0] HI_LIM = NW'(1) << 30;
  localparam logic [NW-1:0] LO_LIM = NW'(1) << 29;

  state_t state;
  logic [1:0] slot;
  logic [3:0] cnt;
  logic [1:0] comp;
  logic       deg;

  vtx_in_t held [2];
  logic [INDEX_BITS-1:0] idx3;
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] e2 [3];
  logic signed [DW-1:0] d1 [2];
  logic signed [DW-1:0] d2 [2];
  logic signed [CW-1:0] cvec [3];
  logic signed [CW-1:0] det;
  logic signed [CW-1:0] acc;
  logic [NW-1:0] mag [3];
  logic [SQ_W-1:0] ssum;
  logic [ROOT_W-1:0] len;
  logic signed [15:0] qv [3];

  logic signed [MUL_W-1:0]   ma;
  logic signed [MUL_W-1:0]   mb;
  logic signed [2*MUL_W-1:0] mp;
  logic [2:0] kp;
  logic signed [CW-1:0] pc;
  logic [1:0] sel;
  logic [NW-1:0] mag_sel;
  logic [NW-1:0] mx;
  logic in_acc;
  logic root_start, div_start;
  unit_stat_t root_stat, div_stat;
  logic [ROOT_W-1:0] root_val;
  logic [QW-1:0] quo;
  logic [15:0] qclamp;
  logic neg;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign kp       = 3'(cnt - 4'd1);
  assign pc       = mp[CW-1:0];
  assign sel      = (state == S_SQ) ? cnt[1:0] : comp;
  assign mag_sel  = mag[sel];
  assign root_start = (state == S_ROOT) && (cnt == 4'd0);
  assign div_start  = (state == S_DIV) && (cnt == 4'd0);
  assign qclamp   = (quo > QW'(ONE_Q14)) ? ONE_Q14 : quo[15:0];
  assign neg      = cvec[comp][CW-1] != det[CW-1];

  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
  end

  always_comb begin
    ma = '0;
    mb = '0;
    if (state == S_SQ) begin
      ma = MUL_W'($signed({1'b0, mag_sel[MAG_W-1:0]}));
      mb = ma;
    end else begin
      case (cnt[2:0])
        3'd0: begin ma = MUL_W'(d2[1]); mb = MUL_W'(e1[0]); end
        3'd1: begin ma = MUL_W'(d1[1]); mb = MUL_W'(e2[0]); end
        3'd2: begin ma = MUL_W'(d2[1]); mb = MUL_W'(e1[1]); end
        3'd3: begin ma = MUL_W'(d1[1]); mb = MUL_W'(e2[1]); end
        3'd4: begin ma = MUL_W'(d2[1]); mb = MUL_W'(e1[2]); end
        3'd5: begin ma = MUL_W'(d1[1]); mb = MUL_W'(e2[2]); end
        3'd6: begin ma = MUL_W'(d1[0]); mb = MUL_W'(d2[1]); end
        3'd7: begin ma = MUL_W'(d2[0]); mb = MUL_W'(d1[1]); end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  ttc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  ttc_root u_root (
    .clk(clk), .rst(rst), .start(root_start), .radicand(ssum),
    .stat(root_stat), .root(root_val)
  );

  ttc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .mag(mag_sel[MAG_W-1:0]),
    .den(len), .stat(div_stat), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot      <= '0;
      cnt       <= '0;
      comp      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_OUT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (slot != 2'd2) begin
              held[slot[0]] <= in_data;
              slot <= slot + 2'd1;
            end else begin
              slot <= '0;
              idx3 <= in_data.vertex_index;
              e1[0] <= shrink(RAW_DW'(held[1].position_x) - RAW_DW'(held[0].position_x));
              e1[1] <= shrink(RAW_DW'(held[1].position_y) - RAW_DW'(held[0].position_y));
              e1[2] <= shrink(RAW_DW'(held[1].position_z) - RAW_DW'(held[0].position_z));
              e2[0] <= shrink(RAW_DW'(in_data.position_x) - RAW_DW'(held[0].position_x));
              e2[1] <= shrink(RAW_DW'(in_data.position_y) - RAW_DW'(held[0].position_y));
              e2[2] <= shrink(RAW_DW'(in_data.position_z) - RAW_DW'(held[0].position_z));
              d1[0] <= shrink(RAW_DW'(held[1].tex_u) - RAW_DW'(held[0].tex_u));
              d1[1] <= shrink(RAW_DW'(held[1].tex_v) - RAW_DW'(held[0].tex_v));
              d2[0] <= shrink(RAW_DW'(in_data.tex_u) - RAW_DW'(held[0].tex_u));
              d2[1] <= shrink(RAW_DW'(in_data.tex_v) - RAW_DW'(held[0].tex_v));
              cnt   <= '0;
              state <= S_PROD;
            end
          end
        end
        S_PROD: begin
          // product k lands in the cycle after issue; odd ones subtract
          if (cnt != 4'd0) begin
            if (!kp[0]) begin
              acc <= pc;
            end else if (kp[2:1] == 2'd3) begin
              det <= acc - pc;
            end else begin
              cvec[kp[2:1]] <= acc - pc;
            end
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd8) state <= S_CHECK;
        end
        S_CHECK: begin
          for (int k = 0; k < 3; k++) begin
            mag[k] <= NW'($unsigned(cvec[k][CW-1] ? -cvec[k] : cvec[k]));
          end
          deg <= (det == '0) ||
                 ((cvec[0] == '0) && (cvec[1] == '0) && (cvec[2] == '0));
          if ((det == '0) ||
              ((cvec[0] == '0) && (cvec[1] == '0) && (cvec[2] == '0))) begin
            for (int k = 0; k < 3; k++) qv[k] <= '0;
            state <= S_OUT;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (mx >= HI_LIM) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 1;
          end else if (mx < LO_LIM) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
          end else begin
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt != 4'd0) begin
            ssum <= ((kp == 3'd0) ? '0 : ssum) + SQ_W'($unsigned(mp));
          end
          if (cnt == 4'd3) begin
            cnt   <= '0;
            state <= S_ROOT;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_ROOT: begin
          if (cnt == 4'd0) cnt <= 4'd1;
          if (root_stat.done) begin
            len   <= root_val;
            cnt   <= '0;
            comp  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == 4'd0) cnt <= 4'd1;
          if (div_stat.done) begin
            qv[comp] <= neg ? -$signed(qclamp) : $signed(qclamp);
            cnt <= '0;
            if (comp == 2'd2) begin
              state <= S_OUT;
            end else begin
              comp <= comp + 2'd1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.tangent_x    <= qv[0];
            out_data.tangent_y    <= qv[1];
            out_data.tangent_z    <= qv[2];
            out_data.first_index  <= held[0].vertex_index;
            out_data.second_index <= held[1].vertex_index;
            out_data.third_index  <= idx3;
            out_data.degenerate   <= deg;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.tangent_x == '0 && out_data.tangent_y == '0 && out_data.tangent_z == '0)
    else $error("degenerate item with nonzero tangent");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.degenerate |->
      out_data.tangent_x <= 16'sd16384 && out_data.tangent_x >= -16'sd16384 &&
      out_data.tangent_y <= 16'sd16384 && out_data.tangent_y >= -16'sd16384 &&
      out_data.tangent_z <= 16'sd16384 && out_data.tangent_z >= -16'sd16384)
    else $error("tangent component out of unit range");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("output loaded outside the output state");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot != 2'd3)
    else $error("vertex slot overflow");
`endif

endmodule
